// ===== rtl/slpq_pkg.sv =====
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and codes for the sorted linked-list priority queue.
// ----------------------------------------------------------------------------
package slpq_pkg;

    localparam int DEF_CAPACITY = 16;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_ORDER_MODE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_F,
        S_INS_H,
        S_WALK,
        S_LINK,
        S_POP,
        S_RESP
    } t_state;

    // p goes ahead of (or ties with) q under the selected order
    function automatic logic precedes(input logic mode, input logic signed [31:0] p,
                                      input logic signed [31:0] q);
        return mode ? (p >= q) : (p <= q);
    endfunction

endpackage

// ===== rtl/sorted_list_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_list_priority_queue
// Priority queue kept as a sorted singly linked list in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_ready) carries one transaction: i_opcode
//   (insert, pop head, peek head) with i_elem_value and i_priority_req.
//   Response channel (o_valid / i_ready) returns exactly one transaction per
//   request: o_status, o_out_value, o_out_priority and o_count.
//   order_mode (APB, byte address 0) picks smallest-first (0) or
//   largest-first (1); change it only while the queue is idle.
// Steps from acceptance to raising o_valid (one request at a time, o_ready
// comes back in that same cycle):
//   no-op, full insert, empty pop/peek : straight to the response.
//   pop, peek, insert into empty queue : one memory step, then the response.
//   other inserts                      : unlink the slot, then walk the list
//                                        one entry per read until the new
//                                        one's place is found, then link it.
//   The walk is set by the link memory: one read per cycle, one slot of
//   the list visited per read.
// Reset (synchronous, active low): queue empty, order_mode 0. No clearing
//   pass: unused slots are handed out from a fill pointer.
// Stall: a finished response waits in the output register; the next request
//   is still accepted and worked on, then its result waits with o_ready low
//   until the older one is taken.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue
    import slpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_elem_value,
    input  logic signed [31:0] i_priority_req,
    // response
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_priority,
    output logic [4:0]         o_count,
    // APB config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // pointer width holds CAPACITY itself, which encodes null
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = 32 + IW;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic               r_order;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_pri, n_pri;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_free, n_free;     // free list head
    logic [IW-1:0]      r_fill, n_fill;     // first slot never handed out
    logic [IW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_slot, n_slot;     // slot taken by this insert
    logic [IW-1:0]      r_cur, n_cur;       // slot being compared
    logic [IW-1:0]      r_prev, n_prev;     // last slot that stays ahead
    logic signed [31:0] r_prev_pri, n_prev_pri;
    logic [1:0]         r_res_status, n_res_status;
    logic signed [31:0] r_res_value, n_res_value;
    logic signed [31:0] r_res_pri, n_res_pri;

    logic               r_o_valid, n_o_valid;
    logic [1:0]         r_o_status, n_o_status;
    logic signed [31:0] r_o_value, n_o_value;
    logic signed [31:0] r_o_pri, n_o_pri;
    logic [IW-1:0]      r_o_count, n_o_count;

    // ------------------------------------------------------------------
    // Memories: link = {priority, next}, value separately.
    // One write and one registered read per cycle each.
    // ------------------------------------------------------------------
    logic [LW-1:0] r_link_mem [CAPACITY];
    logic [31:0]   r_val_mem  [CAPACITY];
    logic [LW-1:0] r_rd_link;
    logic [31:0]   r_rd_val;

    logic [IW-1:0]      w_rd_ptr;
    logic               w_lwe;
    logic [IW-1:0]      w_lw_ptr;
    logic [LW-1:0]      w_lw_data;
    logic               w_vwe;
    logic signed [31:0] w_rd_pri;
    logic [IW-1:0]      w_rd_nxt;
    logic               w_prec;
    logic               w_fresh;
    logic [31:0]        w_count_ext;

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            r_link_mem[w_lw_ptr[AW-1:0]] <= w_lw_data;
        end
        r_rd_link <= r_link_mem[w_rd_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_val_mem[r_slot[AW-1:0]] <= r_val;
        end
        r_rd_val <= r_val_mem[w_rd_ptr[AW-1:0]];
    end

    assign w_rd_pri = $signed(r_rd_link[LW-1 -: 32]);
    assign w_rd_nxt = r_rd_link[IW-1:0];
    assign w_prec   = precedes(r_order, r_pri, w_rd_pri);
    // a slot at the fill pointer was never written; its link is ignored and the next free slot is fill + 1
    assign w_fresh  = (r_slot == r_fill);

    // ------------------------------------------------------------------
    // APB register
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ORDER_MODE) ? {31'd0, r_order} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ORDER_MODE) begin
            r_order <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NIL;
            r_free    <= '0;
            r_fill    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_fill    <= n_fill;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_pri        <= n_pri;
        r_slot       <= n_slot;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_pri   <= n_prev_pri;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_pri    <= n_res_pri;
        r_o_status   <= n_o_status;
        r_o_value    <= n_o_value;
        r_o_pri      <= n_o_pri;
        r_o_count    <= n_o_count;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_pri        = r_pri;
        n_head       = r_head;
        n_free       = r_free;
        n_fill       = r_fill;
        n_count      = r_count;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_pri   = r_prev_pri;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_pri    = r_res_pri;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_value    = r_o_value;
        n_o_pri      = r_o_pri;
        n_o_count    = r_o_count;
        w_rd_ptr     = r_head;
        w_lwe        = 1'b0;
        w_lw_ptr     = r_slot;
        w_lw_data    = {r_pri, NIL};
        w_vwe        = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // start the first read right away
                w_rd_ptr = (i_opcode == OP_INSERT) ? r_free : r_head;
                if (i_valid) begin
                    n_op         = i_opcode;
                    n_val        = i_elem_value;
                    n_pri        = i_priority_req;
                    n_res_status = ST_OK;
                    n_res_value  = '0;
                    n_res_pri    = '0;
                    unique case (i_opcode)
                        OP_INSERT: begin
                            if (r_count >= NIL || r_free == NIL) begin
                                n_res_status = ST_FULL;
                                n_state      = S_RESP;
                            end else begin
                                n_slot  = r_free;
                                n_state = S_INS_F;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count == '0 || r_head == NIL) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            S_INS_F: begin
                // unlink the slot from the free list, store the value
                n_free  = w_fresh ? r_fill + 1'b1 : w_rd_nxt;
                n_fill  = w_fresh ? r_fill + 1'b1 : r_fill;
                n_count = r_count + 1'b1;
                w_vwe   = 1'b1;
                if (r_head == NIL) begin
                    w_lwe   = 1'b1;
                    n_head  = r_slot;
                    n_state = S_RESP;
                end else begin
                    w_rd_ptr = r_head;
                    n_state  = S_INS_H;
                end
            end

            S_INS_H: begin
                if (w_prec) begin
                    w_lwe     = 1'b1;
                    w_lw_data = {r_pri, r_head};
                    n_head    = r_slot;
                    n_state   = S_RESP;
                end else begin
                    n_prev     = r_head;
                    n_prev_pri = w_rd_pri;
                    if (w_rd_nxt == NIL) begin
                        w_lwe   = 1'b1;
                        n_state = S_LINK;
                    end else begin
                        n_cur    = w_rd_nxt;
                        w_rd_ptr = w_rd_nxt;
                        n_state  = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (w_prec) begin
                    w_lwe     = 1'b1;
                    w_lw_data = {r_pri, r_cur};
                    n_state   = S_LINK;
                end else begin
                    n_prev     = r_cur;
                    n_prev_pri = w_rd_pri;
                    if (w_rd_nxt == NIL) begin
                        w_lwe   = 1'b1;
                        n_state = S_LINK;
                    end else begin
                        n_cur    = w_rd_nxt;
                        w_rd_ptr = w_rd_nxt;
                    end
                end
            end

            S_LINK: begin
                // point the predecessor at the new slot
                w_lwe     = 1'b1;
                w_lw_ptr  = r_prev;
                w_lw_data = {r_prev_pri, r_slot};
                n_state   = S_RESP;
            end

            S_POP: begin
                n_res_value = $signed(r_rd_val);
                n_res_pri   = w_rd_pri;
                if (r_op == OP_POP) begin
                    n_head    = w_rd_nxt;
                    w_lwe     = 1'b1;
                    w_lw_ptr  = r_head;
                    w_lw_data = {w_rd_pri, r_free};
                    n_free    = r_head;
                    n_count   = r_count - 1'b1;
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                // also spaces every write from the next read of memory
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_value  = r_res_value;
                    n_o_pri    = r_res_pri;
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_value    = r_o_value;
    assign o_out_priority = r_o_pri;
    assign w_count_ext    = 32'(r_o_count);
    assign o_count        = w_count_ext[4:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above capacity");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == NIL))
        else $error("head pointer disagrees with entry count");

    a_free_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < NIL) |-> (r_free != NIL))
        else $error("free list empty while queue not full");

    a_free_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_fill)
        else $error("free head beyond fill pointer");

    a_fill_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_fill >= $past(r_fill))
        else $error("fill pointer moved backward");

endmodule

// ===== bench/slpq_checker.sv =====
// ----------------------------------------------------------------------------
// slpq_checker
// Watches the request, response and APB ports of the sorted-list priority
// queue. It keeps a private copy of the linked list to predict each response
// and compares every returned transaction field by field, in order.
// ----------------------------------------------------------------------------
module slpq_checker
    import slpq_pkg::*;
#(
    parameter int CAP = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_req_opcode,
    input  logic signed [31:0] i_req_value,
    input  logic signed [31:0] i_req_priority,
    // response channel
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [1:0]         i_rsp_status,
    input  logic signed [31:0] i_rsp_value,
    input  logic signed [31:0] i_rsp_priority,
    input  logic [4:0]         i_rsp_count,
    // APB
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    // status to the top
    output int                 o_pending,
    output int                 o_mismatches,
    output int                 o_checked,
    output int                 o_full_hits,
    output int                 o_empty_hits
);

    localparam int LW = $clog2(CAP + 1);
    localparam logic [LW-1:0] NIL = LW'(CAP);

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [4:0]         count;
    } t_resp;

    // shadow copy of the queue
    logic signed [31:0] slot_val [CAP];
    logic signed [31:0] slot_pri [CAP];
    logic [LW-1:0]      slot_link[CAP];
    logic [LW-1:0]      head_slot;
    logic [LW-1:0]      free_slot;
    logic [4:0]         held;
    logic               largest_first;

    t_resp expected_q[$];
    t_resp want;
    t_resp got;
    t_resp pred;

    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int full_cnt     = 0;
    int empty_cnt    = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_checked    = checked_cnt;
    assign o_full_hits  = full_cnt;
    assign o_empty_hits = empty_cnt;

    function automatic logic goes_ahead(input logic signed [31:0] p,
                                        input logic signed [31:0] q);
        return largest_first ? (p >= q) : (p <= q);
    endfunction

    task automatic clear_queue_model();
        for (int k = 0; k < CAP; k++) begin
            slot_val[k]  = '0;
            slot_pri[k]  = '0;
            slot_link[k] = LW'(k + 1);
        end
        head_slot     = NIL;
        free_slot     = '0;
        held          = '0;
        largest_first = 1'b0;
    endtask

    // Apply one request to the shadow list and return the expected response.
    task automatic apply_request(input logic [1:0] op, input logic signed [31:0] val,
                                 input logic signed [31:0] pri, output t_resp r);
        logic [LW-1:0] slot;
        logic [LW-1:0] prev;
        logic [LW-1:0] cur;
        int            steps;
        r = '{status: ST_OK, value: '0, prio: '0, count: '0};
        case (op)
            OP_INSERT: begin
                if (held >= CAP || free_slot >= NIL) begin
                    r.status = ST_FULL;
                end else begin
                    slot          = free_slot;
                    free_slot     = slot_link[slot];
                    held          = held + 1'b1;
                    slot_val[slot] = val;
                    slot_pri[slot] = pri;
                    if (head_slot == NIL || goes_ahead(pri, slot_pri[head_slot])) begin
                        slot_link[slot] = head_slot;
                        head_slot       = slot;
                    end else begin
                        // new entry lands after every entry it does not precede
                        prev  = head_slot;
                        cur   = slot_link[prev];
                        steps = 0;
                        while (cur != NIL && steps < CAP && !goes_ahead(pri, slot_pri[cur])) begin
                            prev  = cur;
                            cur   = slot_link[cur];
                            steps++;
                        end
                        slot_link[slot] = slot_link[prev];
                        slot_link[prev] = slot;
                    end
                end
            end
            OP_POP, OP_PEEK: begin
                if (held == 0 || head_slot == NIL) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot    = head_slot;
                    r.value = slot_val[slot];
                    r.prio  = slot_pri[slot];
                    if (op == OP_POP) begin
                        head_slot       = slot_link[slot];
                        slot_link[slot] = free_slot;
                        free_slot       = slot;
                        held            = held - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.count = held;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("mismatch on %s: got %h, expected %h (response %0d)",
                 field, seen, wanted, checked_cnt);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_queue_model();
            expected_q.delete();
            o_pending <= 0;
        end else begin
            // responses first: a request taken on the same edge is newer
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{status: i_rsp_status, value: i_rsp_value,
                        prio: i_rsp_priority, count: i_rsp_count};
                if (expected_q.size() == 0) begin
                    report_mismatch("unrequested response", {30'b0, got.status}, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", {30'b0, got.status}, {30'b0, want.status});
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.prio !== want.prio)
                        report_mismatch("priority", got.prio, want.prio);
                    if (got.count !== want.count)
                        report_mismatch("count", {27'b0, got.count}, {27'b0, want.count});
                    checked_cnt++;
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == {REG_ORDER_MODE, 2'b00})
                largest_first = i_pwdata[0];

            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_opcode, i_req_value, i_req_priority, pred);
                if (pred.status == ST_FULL)
                    full_cnt++;
                if (pred.status == ST_EMPTY)
                    empty_cnt++;
                expected_q.push_back(pred);
            end

            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted-list priority queue with a directed opening (empty,
// full, tie and extreme-priority cases, the unused opcode) followed by
// random insert/pop/peek traffic under both priority orders, with random
// request gaps and response stalls. slpq_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import slpq_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    // unused opcode: the queue must answer with a plain no-op
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic ORDER_SMALLEST = 1'b0;
    localparam logic ORDER_LARGEST  = 1'b1;
    localparam logic [2:0] ADDR_ORDER_MODE = {REG_ORDER_MODE, 2'b00};
    // give the pause some margin over the longest insert
    localparam int SETTLE_CYCLES = CAP + 8;
    // worst item: request gap, full list walk and response stall, ~850 items -> well under this
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT = 14;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_elem_value;
    logic signed [31:0] i_priority_req;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_out_value;
    logic signed [31:0] o_out_priority;
    logic [4:0]         o_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int pending;
    int mismatches;
    int checked;
    int full_hits;
    int empty_hits;

    int  cycle_cnt = 0;
    int  sent_cnt;
    int  level;      // entries the queue should hold; steers the op mix
    bit  no_idle;    // when set, neither side inserts wait cycles
    bit  filling;    // current drift of the random traffic

    sorted_list_priority_queue #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_elem_value   (i_elem_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_count        (o_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    slpq_checker #(
        .CAP(CAP)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req_opcode   (i_opcode),
        .i_req_value    (i_elem_value),
        .i_req_priority (i_priority_req),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_rsp_status   (o_status),
        .i_rsp_value    (o_out_value),
        .i_rsp_priority (o_out_priority),
        .i_rsp_count    (o_count),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_pending      (pending),
        .o_mismatches   (mismatches),
        .o_checked      (checked),
        .o_full_hits    (full_hits),
        .o_empty_hits   (empty_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_cnt, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Wait cycles before an item or a response; zero during no-idle stretches.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Priorities: mostly a narrow band so ties are common, plus full-range
    // values and the signed extremes around the sign boundary.
    function automatic logic signed [31:0] draw_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
            5, 6, 7:       return $urandom;
            8:             return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
        endcase
    endfunction

    // Response side: stall a random number of cycles per transaction, then
    // hold ready until the transaction is taken. Ready is never dropped and
    // raised on the same edge.
    initial begin : response_sink
        int stall;
        i_ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        stall = draw_wait();
        forever begin
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            stall = draw_wait();
        end
    end

    // One request transaction; valid and payload hold until accepted.
    task automatic send_request(input logic [1:0] op, input logic signed [31:0] val,
                                input logic signed [31:0] pri);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_elem_value   <= val;
        i_priority_req <= pri;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        sent_cnt++;
        if (op == OP_INSERT && level < CAP)
            level++;
        else if (op == OP_POP && level > 0)
            level--;
    endtask

    // Drain every outstanding response, then give the block time to go idle.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_order_mode(input logic mode);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_ORDER_MODE;
        pwdata  <= {31'b0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic that drifts between filling and draining so the list
    // spends time both nearly empty and full, with long walks in between.
    task automatic run_random(input int n_items);
        int          pick;
        logic [1:0]  op;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if (level == CAP && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (level == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 29) == 0)
                filling = !filling;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_NOP;
            else if (pick < 13)
                op = OP_PEEK;
            else if (pick < (filling ? 72 : 36))
                op = OP_INSERT;
            else
                op = OP_POP;
            send_request(op, $urandom, draw_priority());
        end
    endtask

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_INSERT;
        i_elem_value   <= '0;
        i_priority_req <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        sent_cnt = 0;
        level    = 0;
        no_idle  = 1'b0;
        filling  = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed, smallest-first order from reset ----
        // empty queue: peek and pop report empty, unused opcode is a no-op
        send_request(OP_PEEK, 32'sh12345678, 32'sd5);
        send_request(OP_POP, 32'sh0, 32'sh0);
        send_request(OP_NOP, 32'shffffffff, 32'shffffffff);
        // extremes of value and priority; a tie must land ahead of its equal
        send_request(OP_INSERT, 32'sh7fffffff, 32'sd0);
        send_request(OP_INSERT, 32'sh80000000, 32'sh80000000);
        send_request(OP_INSERT, 32'sd1, 32'sh7fffffff);
        send_request(OP_INSERT, 32'sd2, 32'sd0);
        send_request(OP_PEEK, 32'sd0, 32'sd0);
        send_request(OP_POP, 32'sd0, 32'sd0);
        // fill to capacity with ties around zero, then overflow
        for (int k = 0; k < CAP - 3; k++)
            send_request(OP_INSERT, $urandom, (k % 3) - 1);
        send_request(OP_INSERT, 32'sh55aa55aa, 32'sh0);
        send_request(OP_NOP, 32'sd0, 32'sd0);

        // ---- random phases, switching the order between them ----
        settle();
        write_order_mode(ORDER_LARGEST);
        filling = 1'b0;
        run_random(200);

        settle();
        write_order_mode(ORDER_SMALLEST);
        run_random(210);

        settle();
        write_order_mode(ORDER_LARGEST);
        run_random(210);

        settle();
        write_order_mode(ORDER_SMALLEST);
        run_random(210);

        settle();
        $display("run: %0d requests under both priority orders, %0d responses checked",
                 sent_cnt, checked);
        $display("     %0d inserts hit a full queue, %0d pops/peeks hit an empty one",
                 full_hits, empty_hits);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
